@@ hdl/tbd_pkg.sv @@
// Package for the trail blur and decay core: beat structs, state codes,
// register indexes and fixed-point constants. No dependencies.
package tbd_pkg;

    // Default map limits, handed to the top-level parameters.
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Configuration port geometry.
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IW-1:0] CFG_MAP_WIDTH    = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_MAP_HEIGHT   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_BLUR_WEIGHT  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_DECAY_AMOUNT = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_RED_GAIN     = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_GREEN_GAIN   = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_BLUE_GAIN    = 3'd6;

    // Input opcodes.
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // Q1.15 one.
    localparam logic [15:0] Q_ONE = 16'h8000;

    // Shared multiply-accumulate unit geometry.
    localparam int MAC_W = 19;
    localparam int ACC_W = 2 * MAC_W;

    // floor(sum / 9) == (sum * RECIP9) >> RECIP9_SHIFT for every sum of nine levels.
    localparam logic [MAC_W-1:0] RECIP9       = 19'd466034;
    localparam int               RECIP9_SHIFT = 22;

    // One input beat.
    typedef struct packed {
        logic        opcode;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [15:0] load_level;
    } t_in_item;

    // One result beat.
    typedef struct packed {
        logic [15:0] level_out;
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
        logic        range_error;
    } t_out_item;

    // Control of the shared multiply-accumulate unit.
    typedef struct packed {
        logic en;
        logic clr;
    } t_mac_ctl;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_BLEND_C,
        S_BLEND_A,
        S_DECAY,
        S_RED,
        S_GREEN,
        S_BLUE,
        S_DONE
    } t_state;

endpackage

@@ hdl/trail_blur_decay_core.sv @@
// Top level of the trail blur and decay core: registers, sequencer and datapath.
// Depends on tbd_pkg, tbd_ram and tbd_mac.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+---------------------------
//  input     | start, busy              | i_item (t_in_item)
//  result    | o_strobe                 | o_result (t_out_item)
//  config    | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
// A load beat gives no result; busy stays low.
// A compute beat inside the map keeps busy high for nine reads through the
// single RAM port, then for eight steps, six of them through the one
// multiply-accumulate unit. The result strobe follows in the next cycle.
// A compute beat outside the map gives its result in the cycle after the start.
// Reset is synchronous and clears control and configuration; the trail store
// is not cleared. The result side cannot stall, so results never wait.
module trail_blur_decay_core #(
    parameter int MAX_WIDTH  = tbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tbd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  tbd_pkg::t_in_item          i_item,
    output logic                       o_strobe,
    output tbd_pkg::t_out_item         o_result,
    input  logic                       i_cfg_we,
    input  logic [tbd_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [tbd_pkg::CFG_DW-1:0] i_cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int WCAP  = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
    localparam int HCAP  = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
    localparam int MW    = tbd_pkg::MAC_W;
    localparam int AC    = tbd_pkg::ACC_W;
    localparam int RS    = tbd_pkg::RECIP9_SHIFT;

    // Store address of a cell, row-major with a fixed row pitch.
    function automatic logic [AW-1:0] cell_addr(input logic [8:0] col, input logic [8:0] row);
        cell_addr = AW'(row) * AW'(MAX_WIDTH) + AW'(col);
    endfunction

    // Q1.15 product scaled back and saturated to 16 bits.
    function automatic logic [15:0] sat16(input logic [AC-16:0] v);
        sat16 = (|v[AC-16:16]) ? 16'hFFFF : v[15:0];
    endfunction

    // Configuration registers.
    logic [8:0]  r_map_width;
    logic [8:0]  r_map_height;
    logic [15:0] r_blur_weight;
    logic [15:0] r_decay_amount;
    logic [15:0] r_red_gain;
    logic [15:0] r_green_gain;
    logic [15:0] r_blue_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width    <= 9'd256;
            r_map_height   <= 9'd256;
            r_blur_weight  <= '0;
            r_decay_amount <= '0;
            r_red_gain     <= tbd_pkg::Q_ONE;
            r_green_gain   <= tbd_pkg::Q_ONE;
            r_blue_gain    <= tbd_pkg::Q_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tbd_pkg::CFG_MAP_WIDTH:    r_map_width    <= i_cfg_data[8:0];
                tbd_pkg::CFG_MAP_HEIGHT:   r_map_height   <= i_cfg_data[8:0];
                tbd_pkg::CFG_BLUR_WEIGHT:  r_blur_weight  <= i_cfg_data;
                tbd_pkg::CFG_DECAY_AMOUNT: r_decay_amount <= i_cfg_data;
                tbd_pkg::CFG_RED_GAIN:     r_red_gain     <= i_cfg_data;
                tbd_pkg::CFG_GREEN_GAIN:   r_green_gain   <= i_cfg_data;
                tbd_pkg::CFG_BLUE_GAIN:    r_blue_gain    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Active map size, bounded by the store geometry.
    logic [8:0]  eff_w;
    logic [8:0]  eff_h;
    logic [8:0]  x9;
    logic [8:0]  y9;
    logic [8:0]  x_inc;
    logic [8:0]  y_inc;
    logic [8:0]  xm;
    logic [8:0]  xp;
    logic [8:0]  ym;
    logic [8:0]  yp;
    logic        in_map;
    logic        accept;
    logic [15:0] wt;
    logic [15:0] wt_inv;
    logic [15:0] load_val;

    assign eff_w  = (r_map_width > 9'(WCAP)) ? 9'(WCAP) : r_map_width;
    assign eff_h  = (r_map_height > 9'(HCAP)) ? 9'(HCAP) : r_map_height;
    assign x9     = {1'b0, i_item.pixel_x};
    assign y9     = {1'b0, i_item.pixel_y};
    assign in_map = (x9 < eff_w) && (y9 < eff_h);
    assign accept = start && !busy;

    // Toroidal neighbors of the addressed pixel.
    assign x_inc = x9 + 9'd1;
    assign y_inc = y9 + 9'd1;
    assign xm    = (x9 == 9'd0) ? eff_w - 9'd1 : x9 - 9'd1;
    assign xp    = (x_inc >= eff_w) ? 9'd0 : x_inc;
    assign ym    = (y9 == 9'd0) ? eff_h - 9'd1 : y9 - 9'd1;
    assign yp    = (y_inc >= eff_h) ? 9'd0 : y_inc;

    // Clamped weight, its complement and the clamped load level.
    assign wt       = (r_blur_weight > tbd_pkg::Q_ONE) ? tbd_pkg::Q_ONE : r_blur_weight;
    assign wt_inv   = tbd_pkg::Q_ONE - wt;
    assign load_val = (i_item.load_level > tbd_pkg::Q_ONE) ? tbd_pkg::Q_ONE
                                                           : i_item.load_level;

    // Sequencer state and read counter.
    tbd_pkg::t_state r_state;
    tbd_pkg::t_state n_state;
    logic [3:0]      r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_state == tbd_pkg::S_READ) begin
            r_cnt <= r_cnt + 4'd1;
        end else begin
            r_cnt <= '0;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tbd_pkg::S_IDLE: begin
                if (accept && i_item.opcode == tbd_pkg::OP_COMPUTE && in_map) begin
                    n_state = tbd_pkg::S_READ;
                end
            end
            tbd_pkg::S_READ: begin
                if (r_cnt == 4'd9) begin
                    n_state = tbd_pkg::S_DIV;
                end
            end
            tbd_pkg::S_DIV:     n_state = tbd_pkg::S_BLEND_C;
            tbd_pkg::S_BLEND_C: n_state = tbd_pkg::S_BLEND_A;
            tbd_pkg::S_BLEND_A: n_state = tbd_pkg::S_DECAY;
            tbd_pkg::S_DECAY:   n_state = tbd_pkg::S_RED;
            tbd_pkg::S_RED:     n_state = tbd_pkg::S_GREEN;
            tbd_pkg::S_GREEN:   n_state = tbd_pkg::S_BLUE;
            tbd_pkg::S_BLUE:    n_state = tbd_pkg::S_DONE;
            tbd_pkg::S_DONE:    n_state = tbd_pkg::S_IDLE;
            default:            n_state = tbd_pkg::S_IDLE;
        endcase
    end

    // Neighbor coordinates held for the read sweep.
    logic [8:0] r_xm;
    logic [8:0] r_x;
    logic [8:0] r_xp;
    logic [8:0] r_ym;
    logic [8:0] r_y;
    logic [8:0] r_yp;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_xm <= xm;
            r_x  <= x9;
            r_xp <= xp;
            r_ym <= ym;
            r_y  <= y9;
            r_yp <= yp;
        end
    end

    // Row and column of the neighbor read in this sweep cycle.
    logic [8:0] rd_row;
    logic [8:0] rd_col;

    always_comb begin
        case (r_cnt)
            4'd0, 4'd1, 4'd2: rd_row = r_ym;
            4'd3, 4'd4, 4'd5: rd_row = r_y;
            default:          rd_row = r_yp;
        endcase
        case (r_cnt)
            4'd0, 4'd3, 4'd6: rd_col = r_xm;
            4'd1, 4'd4, 4'd7: rd_col = r_x;
            default:          rd_col = r_xp;
        endcase
    end

    // Trail store: loads write while idle, the sweep reads afterwards.
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [15:0]   ram_rdata;

    assign ram_we   = accept && i_item.opcode == tbd_pkg::OP_LOAD && in_map;
    assign ram_addr = (r_state == tbd_pkg::S_IDLE) ? cell_addr(x9, y9)
                                                   : cell_addr(rd_col, rd_row);

    tbd_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (load_val),
        .o_rdata (ram_rdata)
    );

    // Intermediate values of one compute beat.
    logic [15:0] r_centre;
    logic [15:0] r_avg;
    logic [15:0] r_level;
    logic [15:0] r_red;
    logic [15:0] r_green;

    logic [AC-1:0]    mac_acc;
    tbd_pkg::t_mac_ctl mac_ctl;
    logic [MW-1:0]    mac_a;
    logic [MW-1:0]    mac_b;
    logic [15:0]      blended;
    logic [15:0]      decayed;

    assign blended = mac_acc[30:15];
    assign decayed = (blended > r_decay_amount) ? blended - r_decay_amount : 16'd0;

    // Outputs of the sequencer: busy and the multiply-accumulate schedule.
    always_comb begin
        busy        = (r_state != tbd_pkg::S_IDLE);
        mac_ctl.en  = 1'b0;
        mac_ctl.clr = 1'b0;
        mac_a       = '0;
        mac_b       = '0;
        case (r_state)
            tbd_pkg::S_READ: begin
                // Sum the nine levels, one per cycle as they leave the RAM.
                mac_ctl.en  = (r_cnt != 4'd0);
                mac_ctl.clr = (r_cnt == 4'd1);
                mac_a       = MW'(ram_rdata);
                mac_b       = MW'(1);
            end
            tbd_pkg::S_DIV: begin
                mac_ctl.en  = 1'b1;
                mac_ctl.clr = 1'b1;
                mac_a       = mac_acc[MW-1:0];
                mac_b       = tbd_pkg::RECIP9;
            end
            tbd_pkg::S_BLEND_C: begin
                mac_ctl.en  = 1'b1;
                mac_ctl.clr = 1'b1;
                mac_a       = MW'(r_centre);
                mac_b       = MW'(wt_inv);
            end
            tbd_pkg::S_BLEND_A: begin
                mac_ctl.en  = 1'b1;
                mac_a       = MW'(r_avg);
                mac_b       = MW'(wt);
            end
            tbd_pkg::S_RED: begin
                mac_ctl.en  = 1'b1;
                mac_ctl.clr = 1'b1;
                mac_a       = MW'(r_level);
                mac_b       = MW'(r_red_gain);
            end
            tbd_pkg::S_GREEN: begin
                mac_ctl.en  = 1'b1;
                mac_ctl.clr = 1'b1;
                mac_a       = MW'(r_level);
                mac_b       = MW'(r_green_gain);
            end
            tbd_pkg::S_BLUE: begin
                mac_ctl.en  = 1'b1;
                mac_ctl.clr = 1'b1;
                mac_a       = MW'(r_level);
                mac_b       = MW'(r_blue_gain);
            end
            default: ;
        endcase
    end

    tbd_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .o_acc (mac_acc)
    );

    // Capture the center, average, level and the red and green colors as they come out.
    always_ff @(posedge i_clk) begin
        if (r_state == tbd_pkg::S_READ && r_cnt == 4'd5) begin
            r_centre <= ram_rdata;
        end
        if (r_state == tbd_pkg::S_BLEND_C) begin
            r_avg <= mac_acc[RS+15:RS];
        end
        if (r_state == tbd_pkg::S_DECAY) begin
            r_level <= decayed;
        end
        if (r_state == tbd_pkg::S_GREEN) begin
            r_red <= sat16(mac_acc[AC-1:15]);
        end
        if (r_state == tbd_pkg::S_BLUE) begin
            r_green <= sat16(mac_acc[AC-1:15]);
        end
    end

    // Result register and its one-cycle strobe.
    logic               r_strobe;
    tbd_pkg::t_out_item r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == tbd_pkg::S_DONE)
                     || (accept && i_item.opcode == tbd_pkg::OP_COMPUTE && !in_map);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tbd_pkg::S_DONE) begin
            r_result.level_out   <= r_level;
            r_result.red_out     <= r_red;
            r_result.green_out   <= r_green;
            r_result.blue_out    <= sat16(mac_acc[AC-1:15]);
            r_result.range_error <= 1'b0;
        end else if (accept) begin
            r_result.level_out   <= '0;
            r_result.red_out     <= '0;
            r_result.green_out   <= '0;
            r_result.blue_out    <= '0;
            r_result.range_error <= 1'b1;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

@@ hdl/tbd_ram.sv @@
// Generic single-port RAM with a registered read port.
// No dependencies.
module tbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read data registered; a read in a write cycle returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/tbd_mac.sv @@
// Shared multiply-accumulate unit: one multiplier and one adder into a register.
// Depends on tbd_pkg for widths and the control struct.
module tbd_mac (
    input  logic                      i_clk,
    input  tbd_pkg::t_mac_ctl         i_ctl,
    input  logic [tbd_pkg::MAC_W-1:0] i_a,
    input  logic [tbd_pkg::MAC_W-1:0] i_b,
    output logic [tbd_pkg::ACC_W-1:0] o_acc
);

    logic [tbd_pkg::ACC_W-1:0] r_acc;
    logic [tbd_pkg::ACC_W-1:0] prod;

    assign prod = i_a * i_b;

    // Clear starts a new sum with the current product.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= (i_ctl.clr ? '0 : r_acc) + prod;
        end
    end

    assign o_acc = r_acc;

endmodule

@@ hdl/tbd_checker.sv @@
// Port-level checker for trail_blur_decay_core, with its bind statement.
// Depends on tbd_pkg for the beat structs and opcodes.
module tbd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input tbd_pkg::t_in_item  i_item,
    input logic               o_strobe,
    input tbd_pkg::t_out_item o_result
);

    // An out-of-map result carries only the error flag.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.range_error |->
            o_result.level_out == 16'd0 && o_result.red_out == 16'd0 &&
            o_result.green_out == 16'd0 && o_result.blue_out == 16'd0)
        else $error("range error result with nonzero fields");

    // A load beat never produces a result beat.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.opcode == tbd_pkg::OP_LOAD |=> !o_strobe)
        else $error("result beat after a load");

    // A compute beat either starts work or answers at once.
    a_compute_acts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.opcode == tbd_pkg::OP_COMPUTE |=> busy || o_strobe)
        else $error("compute beat dropped");

    // The level never exceeds one.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_result.level_out <= tbd_pkg::Q_ONE)
        else $error("level above one");

    // Zero level gives zero colors.
    a_zero_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.level_out == 16'd0 |->
            o_result.red_out == 16'd0 && o_result.green_out == 16'd0 &&
            o_result.blue_out == 16'd0)
        else $error("color without level");

endmodule

bind trail_blur_decay_core tbd_checker u_tbd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
